@@ hw/rtl/sads_pkg.sv @@
// Shared constants, codes and controller command type for the dual stack block.
package sads_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ONE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_BOTH = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } sads_ctl_t;

endpackage

@@ hw/rtl/sads_ctrl.sv @@
// Controller state machine: sequences accept, execute and result strobe.
module sads_ctrl
    import sads_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output sads_ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = start ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = (state_reg == S_DONE);
    assign ctl.load = start && (state_reg != S_EXEC);
    assign ctl.exec = (state_reg == S_EXEC);

endmodule

@@ hw/rtl/sads_dp.sv @@
// Datapath: item registers, stack counters, shared store and result registers.
module sads_dp
    import sads_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sads_ctl_t          ctl,
    input  logic [CMD_W-1:0]   cmd,
    input  logic               stack_sel,
    input  logic [DATA_W-1:0]  push_value,
    output logic [STAT_W-1:0]  status,
    output logic [DATA_W-1:0]  top_value,
    output logic [LEVEL_W-1:0] left_level,
    output logic [LEVEL_W-1:0] right_level
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW-1:0] CAP_M1 = CW'(CAPACITY - 1);
    localparam logic [CW:0]   CAP_S  = (CW + 1)'(CAPACITY);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]  cmd_reg;
    logic              sel_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [CW-1:0]     lc_reg;
    logic [CW-1:0]     lc_next;
    logic [CW-1:0]     rc_reg;
    logic [CW-1:0]     rc_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;

    logic [CW:0]       sum;
    logic              full;
    logic              empty;
    logic              we;
    logic              re;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            sel_reg <= stack_sel;
            val_reg <= push_value;
        end
    end

    assign sum   = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign full  = (sum >= CAP_S);
    assign empty = sel_reg ? (rc_reg == '0) : (lc_reg == '0);

    assign wr_addr = sel_reg ? AW'(CAP_M1 - rc_reg) : AW'(lc_reg);
    assign rd_addr = sel_reg ? AW'(CAP_C - rc_reg) : AW'(lc_reg - CW'(1));

    always_comb
    begin
        lc_next     = lc_reg;
        rc_next     = rc_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        case (cmd_reg)
            CMD_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we = 1'b1;
                    if (sel_reg)
                    begin
                        rc_next = rc_reg + CW'(1);
                    end
                    else
                    begin
                        lc_next = lc_reg + CW'(1);
                    end
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (sel_reg)
                begin
                    rc_next = rc_reg - CW'(1);
                end
                else
                begin
                    lc_next = lc_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    re         = 1'b1;
                    rd_ok_next = 1'b1;
                end
            end
            CMD_CLEAR_ONE:
            begin
                if (sel_reg)
                begin
                    rc_next = '0;
                end
                else
                begin
                    lc_next = '0;
                end
            end
            CMD_CLEAR_BOTH:
            begin
                lc_next = '0;
                rc_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && we)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (ctl.exec && re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg     <= '0;
            rc_reg     <= '0;
            status_reg <= ST_OK;
            rd_ok_reg  <= 1'b0;
        end
        else if (ctl.exec)
        begin
            lc_reg     <= lc_next;
            rc_reg     <= rc_next;
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    assign status      = status_reg;
    assign top_value   = rd_ok_reg ? rd_reg : '0;
    assign left_level  = LEVEL_W'(lc_reg);
    assign right_level = LEVEL_W'(rc_reg);

endmodule

@@ hw/rtl/shared_array_dual_stack.sv @@
// Top level of the dual stack block: two byte stacks sharing one store.
//
// Two byte stacks share a store of CAPACITY entries; the left one grows up from entry zero and
// the right one down from the last entry. An item is taken when start is high and busy is low;
// its result appears two cycles later on status, top_value, left_level and right_level for one
// cycle with done high, and must be captured then, as it cannot be held off. busy is high only
// in the execute cycle, so a new item may be started in the cycle its predecessor's result
// shows, giving one item every two cycles: one cycle for the store access, one for the
// registered read data. The levels are the low seven bits of each stack's count.
module shared_array_dual_stack
    import sads_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic               stack_sel,
    input  logic [DATA_W-1:0]  push_value,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [DATA_W-1:0]  top_value,
    output logic [LEVEL_W-1:0] left_level,
    output logic [LEVEL_W-1:0] right_level
);

    sads_ctl_t ctl;

    sads_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    sads_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (cmd),
        .stack_sel   (stack_sel),
        .push_value  (push_value),
        .status      (status),
        .top_value   (top_value),
        .left_level  (left_level),
        .right_level (right_level)
    );

endmodule

@@ tb/shared_array_dual_stack_tb.sv @@
// Self-checking testbench for the two-stack shared store block.
`timescale 1ns / 100ps

module shared_array_dual_stack_tb
    import sads_pkg::*;
;

    localparam int CAP        = DEF_CAPACITY;
    localparam int RAND_ITEMS = 1250;
    localparam int PHASE_B    = 420;
    localparam int PHASE_C    = 840;
    localparam int QUIET_MAX  = 2000;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic              sel;
        logic [DATA_W-1:0] val;
    } stack_item_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  top;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
    } stack_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [CMD_W-1:0]   cmd = '0;
    logic               stack_sel = 1'b0;
    logic [DATA_W-1:0]  push_value = '0;
    logic               busy;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  top_value;
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;

    stack_item_t   pending_items[$];
    stack_answer_t expected_answers[$];

    logic [DATA_W-1:0] model_mem [CAP];
    int model_left  = 0;
    int model_right = 0;

    int issued_cnt = 0;
    int seen_cnt   = 0;
    int err_count  = 0;
    int quiet_cnt  = 0;
    logic all_sent = 1'b0;

    shared_array_dual_stack #(.CAPACITY(CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .stack_sel   (stack_sel),
        .push_value  (push_value),
        .done        (done),
        .status      (status),
        .top_value   (top_value),
        .left_level  (left_level),
        .right_level (right_level)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic stack_answer_t predict_stack_answer(stack_item_t it);
        stack_answer_t a;
        int depth;
        a.status = ST_OK;
        a.top    = '0;
        depth    = it.sel ? model_right : model_left;
        case (it.op)
            CMD_PUSH:
            begin
                if (model_left + model_right >= CAP)
                    a.status = ST_FULL;
                else if (it.sel)
                begin
                    model_right++;
                    model_mem[CAP - model_right] = it.val;
                end
                else
                begin
                    model_mem[model_left] = it.val;
                    model_left++;
                end
            end
            CMD_POP:
            begin
                if (depth == 0)
                    a.status = ST_EMPTY;
                else if (it.sel)
                    model_right--;
                else
                    model_left--;
            end
            CMD_READ:
            begin
                if (depth == 0)
                    a.status = ST_EMPTY;
                else
                    a.top = it.sel ? model_mem[CAP - model_right] : model_mem[model_left - 1];
            end
            CMD_CLEAR_ONE:
            begin
                if (it.sel)
                    model_right = 0;
                else
                    model_left = 0;
            end
            CMD_CLEAR_BOTH:
            begin
                model_left  = 0;
                model_right = 0;
            end
            default: ;
        endcase
        a.left  = LEVEL_W'(model_left);
        a.right = LEVEL_W'(model_right);
        return a;
    endfunction

    task automatic add_item(logic [CMD_W-1:0] op, logic sel, logic [DATA_W-1:0] val);
        stack_item_t it;
        it.op  = op;
        it.sel = sel;
        it.val = val;
        pending_items.push_back(it);
    endtask

    // Driver: hold an item until taken, idle by phase, drain at phase changes.
    always @(posedge clk)
    begin : drive_proc
        logic take;
        logic go;
        int   taken;
        int   idle_pct;
        stack_item_t cur;
        if (rst_n)
        begin
            take = start && !busy;
            if (take)
            begin
                cur.op  = cmd;
                cur.sel = stack_sel;
                cur.val = push_value;
                expected_answers.push_back(predict_stack_answer(cur));
                void'(pending_items.pop_front());
                issued_cnt <= issued_cnt + 1;
            end
            taken    = issued_cnt + (take ? 1 : 0);
            idle_pct = (taken < PHASE_B) ? 32 : (taken < PHASE_C) ? 70 : 0;
            if (start && !take)
                go = 1'b1;
            else if (pending_items.size() == 0)
                go = 1'b0;
            else if ((taken == PHASE_B || taken == PHASE_C) && (take || issued_cnt != seen_cnt))
                go = 1'b0;
            else
                go = ($urandom_range(99) >= idle_pct);
            start <= go;
            if (go)
            begin
                cmd        <= pending_items[0].op;
                stack_sel  <= pending_items[0].sel;
                push_value <= pending_items[0].val;
            end
            all_sent <= (pending_items.size() == 0) && !go;
        end
    end

    // Monitor: compare every strobed result with the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        stack_answer_t exp;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("result with no item: st=%0d top=%0h l=%0d r=%0d",
                             status, top_value, left_level, right_level);
            end
            else
            begin
                exp = expected_answers.pop_front();
                seen_cnt <= seen_cnt + 1;
                if (status !== exp.status || top_value !== exp.top ||
                    left_level !== exp.left || right_level !== exp.right)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("mismatch %0d: exp %0d/%0h/%0d/%0d got %0d/%0h/%0d/%0d",
                                 seen_cnt, exp.status, exp.top, exp.left, exp.right,
                                 status, top_value, left_level, right_level);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= QUIET_MAX)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stim_proc
        int made;
        int kind;
        int len;
        int sel_mode;
        int r;
        logic [CMD_W-1:0]  op;
        logic              s;
        logic [DATA_W-1:0] v;

        add_item(CMD_POP,        1'b0, 8'h00);
        add_item(CMD_POP,        1'b1, 8'hFF);
        add_item(CMD_READ,       1'b0, 8'h00);
        add_item(CMD_READ,       1'b1, 8'hFF);
        add_item(CMD_PUSH,       1'b0, 8'h00);
        add_item(CMD_PUSH,       1'b1, 8'hFF);
        add_item(CMD_READ,       1'b0, 8'h00);
        add_item(CMD_READ,       1'b1, 8'h00);
        add_item(CMD_PUSH,       1'b0, 8'h80);
        add_item(CMD_PUSH,       1'b1, 8'h01);
        add_item(CMD_READ,       1'b0, 8'hFF);
        add_item(CMD_READ,       1'b1, 8'hFF);
        add_item(CMD_POP,        1'b0, 8'h00);
        add_item(CMD_READ,       1'b0, 8'h00);
        add_item(CMD_POP,        1'b1, 8'h00);
        add_item(CMD_READ,       1'b1, 8'h00);
        add_item(CMD_CLEAR_ONE,  1'b0, 8'hFF);
        add_item(CMD_READ,       1'b0, 8'h00);
        add_item(CMD_CLEAR_ONE,  1'b1, 8'h00);
        add_item(CMD_PUSH,       1'b0, 8'h5A);
        add_item(CMD_CLEAR_BOTH, 1'b1, 8'hA5);
        add_item(CMD_POP,        1'b0, 8'h00);
        add_item(3'd5,           1'b1, 8'hFF);
        add_item(3'd6,           1'b0, 8'h00);
        add_item(3'd7,           1'b1, 8'hFF);

        // Bursts: fills that run into full, push- or pop-leaning runs, mixed, noise.
        made = 0;
        while (made < RAND_ITEMS)
        begin
            kind     = $urandom_range(9);
            len      = $urandom_range(70, 20);
            sel_mode = $urandom_range(2);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(99);
                s = (sel_mode == 2) ? 1'($urandom_range(1)) : 1'(sel_mode);
                v = 8'($urandom_range(255));
                if (kind <= 2)
                    op = CMD_PUSH;
                else if (kind <= 4)
                    op = (r < 70) ? CMD_PUSH : (r < 85) ? CMD_READ : CMD_POP;
                else if (kind <= 6)
                    op = (r < 60) ? CMD_POP : (r < 80) ? CMD_READ : CMD_PUSH;
                else if (kind == 7)
                    op = (r < 35) ? CMD_PUSH : (r < 60) ? CMD_POP :
                         (r < 90) ? CMD_READ : CMD_CLEAR_ONE;
                else
                    op = CMD_W'($urandom_range(7));
                add_item(op, s, v);
                if (op <= CMD_CLEAR_BOTH)
                    made++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(all_sent && issued_cnt == seen_cnt));
        repeat (10) @(negedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sads_pkg.sv
hw/rtl/sads_ctrl.sv
hw/rtl/sads_dp.sv
hw/rtl/shared_array_dual_stack.sv
tb/shared_array_dual_stack_tb.sv
